// ===== rtl/core/kyg_pkg.sv =====
// ----------------------------------------------------------------------------
// kyg_pkg: shared types and constants of the Knuth-Yao sampler
// Default geometry, field widths, register map and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kyg_pkg;

   localparam int ROWS_DEFAULT = 64;
   localparam int COLS_DEFAULT = 128;

   localparam int TOP_ROW_W  = 6;
   localparam int SAMPLE_W   = 7;
   localparam int DIST_W     = 8;
   localparam int WORD_W     = 64;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOP_ROW_W-1:0]  TOP_ROW_RESET = 6'd63;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP_ROW   = 2'd0;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_BIT  = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load_we;    // write one table word from the request
      logic sign_load;  // take the request bit as sign
      logic walk_init;  // start a row scan for the request bit
      logic rd_en;      // read the table word of the issue row
      logic eval_en;    // evaluate the word read in the previous cycle
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sign_pending;
      logic issue_last;  // issue row is row 0
      logic eval_last;   // evaluated row is row 0
      logic hit;         // distance reached -1 on the evaluated row
   } status_type;

endpackage : kyg_pkg

`default_nettype wire

// ===== rtl/core/knuth_yao_gaussian_sampler_core.sv =====
// ----------------------------------------------------------------------------
// knuth_yao_gaussian_sampler_core: Knuth-Yao discrete Gaussian sampler
// Walks a stored probability bit matrix driven by one random bit per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a beat is taken at a rising edge with start high and
//   busy low. req_mode = 0 writes req_word_data into word req_word_index of
//   table row req_row_index; req_mode = 1 hands in one random bit.
//   The first bit of a sample picks the sign (0 = positive); each later bit
//   scans one table column from row top_row down to row 0.
//   Result channel: rsp_strobe marks rsp_sample for exactly one cycle. The
//   receiver cannot stall, so a result must be taken when it shows.
//   Timing: a load beat or a sign bit leaves busy low. A walk bit holds
//   busy while the scan runs over R = min(top_row + 1, ROWS) rows: the scan
//   reads one table word per cycle from a single memory port, and each
//   word is evaluated in the cycle after its read. A hit ends the scan
//   early; its sample strobes in the first cycle with busy low again.
//   Configuration: top_row at APB address 0, to be written only while idle (not enforced).
//   Reset: the walk restarts with a sign bit pending and top_row = 63. The
//   table is not cleared; rows must be loaded before sampling.
// ----------------------------------------------------------------------------
`default_nettype none

module knuth_yao_gaussian_sampler_core
   import kyg_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   // request channel
   input  wire                        start,
   output logic                       busy,
   input  wire                        req_mode,
   input  wire  [5:0]                 req_row_index,
   input  wire                        req_word_index,
   input  wire  [WORD_W-1:0]          req_word_data,
   input  wire                        req_random_bit,
   // result channel
   output logic                       rsp_strobe,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   // configuration port
   input  wire                        psel,
   input  wire                        penable,
   input  wire                        pwrite,
   input  wire  [CSR_ADDR_W-1:0]      paddr,
   input  wire  [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   cmd_type    cmd;
   status_type status;

   logic [TOP_ROW_W-1:0] top_row_ff;
   logic [TOP_ROW_W-1:0] top_row_in;
   logic                 csr_write;

   // register write completes in the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == CSR_TOP_ROW);
   assign top_row_in = csr_write ? pwdata[TOP_ROW_W-1:0] : top_row_ff;
   assign prdata     = (paddr == CSR_TOP_ROW)
                       ? {{(CSR_DATA_W-TOP_ROW_W){1'b0}}, top_row_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_row_ff <= TOP_ROW_RESET;
      end else begin
         top_row_ff <= top_row_in;
      end
   end

   kyg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .status   (status),
      .cmd      (cmd)
   );

   kyg_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .top_row        (top_row_ff),
      .req_row_index  (req_row_index),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_random_bit (req_random_bit),
      .rsp_strobe     (rsp_strobe),
      .rsp_sample     (rsp_sample)
   );

endmodule : knuth_yao_gaussian_sampler_core

`default_nettype wire

// ===== rtl/core/kyg_ctrl.sv =====
// ----------------------------------------------------------------------------
// kyg_ctrl: sampler sequencer
// Accepts requests and steps the two-stage table scan (read, evaluate).
// ----------------------------------------------------------------------------
`default_nettype none

module kyg_ctrl
   import kyg_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   input  wire        req_mode,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   logic      issue_ff;
   logic      eval_ff;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.load_we   = accept && (req_mode == MODE_LOAD);
      cmd.sign_load = accept && (req_mode == MODE_BIT) && status.sign_pending;
      cmd.walk_init = accept && (req_mode == MODE_BIT) && !status.sign_pending;
      cmd.rd_en     = (state_ff == ST_SCAN) && issue_ff;
      cmd.eval_en   = (state_ff == ST_SCAN) && eval_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
         eval_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.walk_init) begin
                  state_ff <= ST_SCAN;
                  issue_ff <= 1'b1;
                  eval_ff  <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (eval_ff && (status.hit || status.eval_last)) begin
                  // done: drop the read still in flight
                  state_ff <= ST_IDLE;
                  issue_ff <= 1'b0;
                  eval_ff  <= 1'b0;
               end else begin
                  eval_ff <= issue_ff;
                  if (issue_ff && status.issue_last) begin
                     issue_ff <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule : kyg_ctrl

`default_nettype wire

// ===== rtl/core/kyg_datapath.sv =====
// ----------------------------------------------------------------------------
// kyg_datapath: table memory and walk state
// Holds the probability bit matrix, distance, column, sign and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module kyg_datapath
   import kyg_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  wire  [TOP_ROW_W-1:0]       top_row,
   input  wire  [5:0]                 req_row_index,
   input  wire                        req_word_index,
   input  wire  [WORD_W-1:0]          req_word_data,
   input  wire                        req_random_bit,
   output logic                       rsp_strobe,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

   localparam int WPR    = (COLS + WORD_W - 1) / WORD_W;
   localparam int DEPTH  = ROWS * WPR;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);

   logic [WORD_W-1:0] mem [DEPTH];

   logic [WORD_W-1:0]          rdata_ff;
   logic [ROW_W-1:0]           issue_row_ff;
   logic [ROW_W-1:0]           tag_row_ff;
   logic [DIST_W:0]            d_ff;
   logic [DIST_W-1:0]          distance_ff;
   logic [COL_W-1:0]           column_ff;
   logic                       sign_pending_ff;
   logic                       sign_negative_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   logic              load_ok;
   logic [ADDR_W-1:0] ld_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [COL_W-1:0]  col_word;
   logic [5:0]        bit_pos;
   logic              cur_bit;
   logic [ROW_W-1:0]  start_row;
   logic [DIST_W:0]   d_in;
   logic [DIST_W:0]   d_dec;
   logic [DIST_W-1:0] dist_sat;
   logic [8:0]        mag;
   logic [8:0]        mag_neg;

   assign load_ok = ({3'b000, req_row_index} < 9'(ROWS))
                    && ({2'b00, req_word_index} < 3'(WPR));
   assign ld_addr = ADDR_W'(int'(req_row_index) * WPR + int'(req_word_index));
   assign col_word = column_ff >> 6;
   assign rd_addr  = ADDR_W'(int'(issue_row_ff) * WPR + int'(col_word));
   assign bit_pos  = 6'd63 - column_ff[5:0];
   assign cur_bit  = rdata_ff[bit_pos];

   // rows at or above ROWS hold no bits, so start at the last real row
   assign start_row = (9'(top_row) >= 9'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(top_row);
   assign d_in      = {distance_ff, 1'b0} + {{DIST_W{1'b0}}, ~req_random_bit};
   assign d_dec     = d_ff - {{DIST_W{1'b0}}, cur_bit};
   assign dist_sat  = d_dec[DIST_W] ? {DIST_W{1'b1}} : d_dec[DIST_W-1:0];
   assign mag       = 9'(tag_row_ff);
   assign mag_neg   = 9'd0 - mag;

   assign status.sign_pending = sign_pending_ff;
   assign status.issue_last   = (issue_row_ff == '0);
   assign status.eval_last    = (tag_row_ff == '0);
   assign status.hit          = cmd.eval_en && (d_ff == '0) && cur_bit;

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_we && load_ok) begin
         mem[ld_addr] <= req_word_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         issue_row_ff <= start_row;
         d_ff         <= d_in;
      end else begin
         if (cmd.rd_en) begin
            issue_row_ff <= issue_row_ff - 1'b1;
            tag_row_ff   <= issue_row_ff;
         end
         if (cmd.eval_en) begin
            d_ff <= d_dec;
         end
      end
      if (status.hit) begin
         rsp_sample_ff <= sign_negative_ff ? mag_neg[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
      end
   end

   // walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff      <= '0;
         column_ff        <= '0;
         sign_pending_ff  <= 1'b1;
         sign_negative_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= status.hit;
         if (cmd.sign_load) begin
            sign_negative_ff <= req_random_bit;
            sign_pending_ff  <= 1'b0;
            distance_ff      <= '0;
            column_ff        <= '0;
         end else if (status.hit) begin
            sign_pending_ff  <= 1'b1;
            sign_negative_ff <= 1'b0;
            distance_ff      <= '0;
            column_ff        <= '0;
         end else if (cmd.eval_en && status.eval_last) begin
            // no hit in this column: advance, restart after the last one
            if (column_ff == COL_W'(COLS - 1)) begin
               column_ff   <= '0;
               distance_ff <= '0;
            end else begin
               column_ff   <= column_ff + 1'b1;
               distance_ff <= dist_sat;
            end
         end
      end
   end

endmodule : kyg_datapath

`default_nettype wire

// ===== rtl/core/kyg_checker.sv =====
// ----------------------------------------------------------------------------
// kyg_checker: port-level checks of the sampler
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module kyg_checker (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire req_mode,
   input wire rsp_strobe
);

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // a load beat never starts a scan
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_mode) |=> !busy)
      else $error("load beat made the block busy");

   // a result follows the cycle that ended a scan
   a_result_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result without a finished scan");

   // a sample strobes for one cycle only
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

endmodule : kyg_checker

bind knuth_yao_gaussian_sampler_core kyg_checker u_kyg_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_mode   (req_mode),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire

// ===== tb/knuth_yao_gaussian_sampler_core_test.sv =====
// ----------------------------------------------------------------------------
// knuth_yao_gaussian_sampler_core_test: self-checking bench for the sampler
// Loads the probability table over the request channel and feeds random bits.
// A local copy of the Knuth-Yao walk predicts every sample. Strobed samples
// are matched in order against that prediction. The run covers directed edge
// cases, several top_row settings, sparse and dense tables, distance
// saturation and the column wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module knuth_yao_gaussian_sampler_core_test;
   import kyg_pkg::*;

   localparam int SETTLE_CYCLES  = ROWS_DEFAULT + 8;  // longest scan plus margin
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DIST_MAX       = (1 << DIST_W) - 1;
   localparam int WORDS_PER_ROW  = COLS_DEFAULT / WORD_W;
   localparam logic TYPED = 1'b1;  // directed row carries its own expected sample
   localparam logic PRED  = 1'b0;  // expected sample comes from the walk predictor
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic                       mode;
      logic [5:0]                 row;
      logic                       word;
      logic [WORD_W-1:0]          data;
      logic                       rbit;
      logic                       typed;
      logic signed [SAMPLE_W-1:0] val;
   } beat_row_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_mode;
   logic [5:0]                 req_row_index;
   logic                       req_word_index;
   logic [WORD_W-1:0]          req_word_data;
   logic                       req_random_bit;
   logic                       rsp_strobe;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_W-1:0]      paddr;
   logic [CSR_DATA_W-1:0]      pwdata;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   // walk predictor state
   logic [WORD_W-1:0]          tbl_words [ROWS_DEFAULT][WORDS_PER_ROW];
   int                         walk_dist;
   int                         walk_col;
   logic                       expect_sign;
   logic                       sign_neg;
   logic [TOP_ROW_W-1:0]       top_row_q;

   logic signed [SAMPLE_W-1:0] pending_samples [$];
   logic signed [SAMPLE_W-1:0] want_sample;
   beat_row_type               directed_rows [18];

   int failures        = 0;
   int beats_taken     = 0;
   int loads_taken     = 0;
   int bits_taken      = 0;
   int samples_checked = 0;
   int settings_seen   = 0;
   int idle_cycles     = 0;
   int stretch_left    = 0;
   bit quiet_stretch   = 0;

   knuth_yao_gaussian_sampler_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_row_index  (req_row_index),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_random_bit (req_random_bit),
      .rsp_strobe     (rsp_strobe),
      .rsp_sample     (rsp_sample),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Advance the walk by one beat. A load updates the table; a sign bit
   // arms the walk; a walk bit scans the current column from top_row down
   // and reports a hit with the signed row.
   function automatic void sampler_walk(input logic mode, input logic [5:0] row,
                                        input logic word, input logic [WORD_W-1:0] data,
                                        input logic rbit, output bit hit,
                                        output logic signed [SAMPLE_W-1:0] smp);
      int d;
      int r;
      hit = 1'b0;
      smp = '0;
      if (mode == MODE_LOAD) begin
         tbl_words[row][word] = data;
         return;
      end
      if (expect_sign) begin
         sign_neg    = rbit;
         expect_sign = 1'b0;
         walk_dist   = 0;
         walk_col    = 0;
         return;
      end
      d = 2 * walk_dist + (rbit ? 0 : 1);
      for (r = int'(top_row_q); r >= 0; r--) begin
         d = d - int'(tbl_words[r][walk_col / WORD_W][WORD_W - 1 - walk_col % WORD_W]);
         if (d == -1) begin
            hit         = 1'b1;
            // a negative sign on row 0 still gives zero
            smp         = sign_neg ? SAMPLE_W'(-r) : SAMPLE_W'(r);
            expect_sign = 1'b1;
            sign_neg    = 1'b0;
            walk_dist   = 0;
            walk_col    = 0;
            return;
         end
      end
      // no hit: saturate the distance and move to the next column
      walk_dist = (d > DIST_MAX) ? DIST_MAX : d;
      walk_col++;
      if (walk_col >= COLS_DEFAULT) begin
         walk_col  = 0;
         walk_dist = 0;
      end
   endfunction

   // One bit in one_in is set; 0 gives an empty word, 2 or less a uniform one.
   function automatic logic [WORD_W-1:0] rand_word(input int one_in);
      logic [WORD_W-1:0] w;
      if (one_in == 0) return '0;
      if (one_in <= 2) return {$urandom, $urandom};
      for (int i = 0; i < WORD_W; i++) w[i] = ($urandom_range(one_in - 1) == 0);
      return w;
   endfunction

   // Drop start for a random gap; some stretches of beats run back to back.
   task automatic sender_pause();
      int roll;
      int n;
      if (stretch_left == 0) begin
         stretch_left  = $urandom_range(60, 20);
         quiet_stretch = ($urandom_range(3) == 0);
      end
      stretch_left--;
      if (quiet_stretch) return;
      roll = $urandom_range(99);
      n = (roll < 65) ? 0 : (roll < 93) ? $urandom_range(3, 1) : $urandom_range(60, 8);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one beat, hold it until taken, then log what it should produce.
   // Start stays high on return so the next beat can follow without a gap.
   task automatic send_beat(input logic mode, input logic [5:0] row, input logic word,
                            input logic [WORD_W-1:0] data, input logic rbit,
                            input logic typed, input logic signed [SAMPLE_W-1:0] typed_val);
      bit hit;
      logic signed [SAMPLE_W-1:0] smp;
      sender_pause();
      start          <= 1'b1;
      req_mode       <= mode;
      req_row_index  <= row;
      req_word_index <= word;
      req_word_data  <= data;
      req_random_bit <= rbit;
      do @(posedge clock); while (busy);
      sampler_walk(mode, row, word, data, rbit, hit, smp);
      if (typed) pending_samples.push_back(typed_val);
      else if (hit) pending_samples.push_back(smp);
      beats_taken++;
      if (mode == MODE_LOAD) loads_taken++;
      else bits_taken++;
   endtask

   task automatic send_random_load(input int one_in);
      send_beat(MODE_LOAD, 6'($urandom_range(ROWS_DEFAULT - 1)), 1'($urandom_range(1)),
                rand_word(one_in), 1'($urandom_range(1)), PRED, '0);
   endtask

   // Unused fields of a bit beat carry noise.
   task automatic send_random_bit();
      send_beat(MODE_BIT, 6'($urandom_range(ROWS_DEFAULT - 1)), 1'($urandom_range(1)),
                {$urandom, $urandom}, 1'($urandom_range(1)), PRED, '0);
   endtask

   task automatic reload_table(input int one_in);
      for (int r = 0; r < ROWS_DEFAULT; r++)
         for (int w = 0; w < WORDS_PER_ROW; w++)
            send_beat(MODE_LOAD, 6'(r), 1'(w), rand_word(one_in), 1'($urandom_range(1)),
                      PRED, '0);
   endtask

   // Hold off new beats until every sample is in, then let a full scan pass,
   // since a walk bit without a hit leaves nothing to wait for.
   task automatic settle();
      start <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write top_row while idle, with noise in the unused upper bits, and
   // read it back.
   task automatic set_top_row(input int value);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] rdata;
      wdata = $urandom;
      wdata[TOP_ROW_W-1:0] = TOP_ROW_W'(value);
      settle();
      csr_write(CSR_TOP_ROW, wdata);
      top_row_q = wdata[TOP_ROW_W-1:0];
      @(posedge clock);
      csr_read(CSR_TOP_ROW, rdata);
      if (rdata !== CSR_DATA_W'(top_row_q)) begin
         $error("top_row: expected %0d, got %0d", top_row_q, rdata);
         failures++;
      end
      settings_seen++;
   endtask

   // Reload part of the table, then stream walk bits with loads mixed in.
   task automatic run_phase(input int top, input int one_in, input int reloads, input int nbits);
      set_top_row(top);
      repeat (reloads) send_random_load(one_in);
      repeat (nbits) begin
         if ($urandom_range(99) < 8) send_random_load(one_in);
         else send_random_bit();
      end
   endtask

   // Match each strobed sample against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_samples.size() == 0) begin
            $error("sample: expected none, got %0d", rsp_sample);
            failures++;
         end else begin
            want_sample = pending_samples.pop_front();
            if (rsp_sample !== want_sample) begin
               $error("sample: expected %0d, got %0d", want_sample, rsp_sample);
               failures++;
            end
            samples_checked++;
         end
      end
   end

   // Stop a hung run: count cycles in which no beat, sample or register
   // access goes through.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] rdata;

      // Directed beats, starting from an all-zero table with top_row 63.
      directed_rows = '{
         '{MODE_LOAD, 6'd0,  1'b0, ALL_ONES,               1'b0, PRED,  7'sd0},
         '{MODE_LOAD, 6'd63, 1'b0, 64'h8000_0000_0000_0000, 1'b0, PRED,  7'sd0},
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b0, PRED,  7'sd0},   // sign +
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, TYPED, 7'sd63},  // top row hit
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, PRED,  7'sd0},   // sign -
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, TYPED, -7'sd63}, // most negative
         '{MODE_LOAD, 6'd63, 1'b0, 64'h0,                  1'b0, PRED,  7'sd0},
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, PRED,  7'sd0},   // sign -
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, TYPED, 7'sd0},   // negative zero
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b0, PRED,  7'sd0},   // sign +
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b0, PRED,  7'sd0},   // miss, column 1
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, TYPED, 7'sd0},   // row 0 hit
         '{MODE_LOAD, 6'd63, 1'b1, ALL_ONES,               1'b1, PRED,  7'sd0},
         '{MODE_LOAD, 6'd5,  1'b1, 64'hA5A5_5A5A_C3C3_3C3C, 1'b0, PRED,  7'sd0},
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, PRED,  7'sd0},
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b0, PRED,  7'sd0},
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b0, PRED,  7'sd0},
         '{MODE_BIT,  6'd0,  1'b0, 64'h0,                  1'b1, PRED,  7'sd0}
      };

      // Drive every input to a known value and hold reset.
      reset          <= 1'b1;
      start          <= 1'b0;
      req_mode       <= MODE_LOAD;
      req_row_index  <= '0;
      req_word_index <= 1'b0;
      req_word_data  <= '0;
      req_random_bit <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= CSR_TOP_ROW;
      pwdata         <= '0;
      expect_sign    = 1'b1;
      sign_neg       = 1'b0;
      walk_dist      = 0;
      walk_col       = 0;
      top_row_q      = TOP_ROW_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Check the reset value of top_row.
      csr_read(CSR_TOP_ROW, rdata);
      if (rdata !== CSR_DATA_W'(TOP_ROW_RESET)) begin
         $error("top_row: expected %0d, got %0d", TOP_ROW_RESET, rdata);
         failures++;
      end

      // Clear the whole table first so no scan reads an unwritten word.
      reload_table(0);
      foreach (directed_rows[i])
         send_beat(directed_rows[i].mode, directed_rows[i].row, directed_rows[i].word,
                   directed_rows[i].data, directed_rows[i].rbit, directed_rows[i].typed,
                   directed_rows[i].val);

      // Random walks over tables of varying density and top_row extremes.
      reload_table(2);
      run_phase(63, 2, 0, 70);
      run_phase(0, 4, 20, 70);
      run_phase(63, 16, 40, 70);
      run_phase(31, 8, 24, 70);
      run_phase($urandom_range(62, 1), 64, 24, 70);

      // Empty row 0 with top_row 0: every bit misses, so the distance
      // saturates and the column wraps. Then refill and resume sampling.
      set_top_row(0);
      send_beat(MODE_LOAD, 6'd0, 1'b0, 64'h0, 1'b0, PRED, '0);
      send_beat(MODE_LOAD, 6'd0, 1'b1, 64'h0, 1'b1, PRED, '0);
      repeat (140) send_random_bit();
      send_beat(MODE_LOAD, 6'd0, 1'b0, rand_word(2), 1'b0, PRED, '0);
      repeat (20) send_random_bit();

      run_phase(63, 3, 24, 70);
      run_phase($urandom_range(62, 1), 6, 24, 70);

      // Drain every outstanding sample, then report.
      settle();
      $display("Covered %0d beats (%0d table loads, %0d random bits) over %0d top_row settings.",
               beats_taken, loads_taken, bits_taken, settings_seen);
      $display("Checked %0d samples with %0d mismatches.", samples_checked, failures);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : knuth_yao_gaussian_sampler_core_test

`default_nettype wire

// ===== filelist.f =====
rtl/core/kyg_pkg.sv
rtl/core/kyg_ctrl.sv
rtl/core/kyg_datapath.sv
rtl/core/knuth_yao_gaussian_sampler_core.sv
rtl/core/kyg_checker.sv
tb/knuth_yao_gaussian_sampler_core_test.sv
